FILE: rtl/tut_pkg.sv
// Shared types and constants for the triangle UV tangent block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package tut_pkg;

  // Default sizes of the input fields and of the tangent fraction.
  localparam int POSITION_BITS_DEF     = 32;
  localparam int TEXCOORD_BITS_DEF     = 24;
  localparam int TANGENT_FRAC_BITS_DEF = 14;

  // Edge widths after any scaling of wide inputs.
  localparam int EP_W  = 33;
  localparam int ET_W  = 25;
  // Width of one tangent component before normalization.
  localparam int T_W   = 59;
  // Shared multiplier operand width and accumulator width.
  localparam int MUL_W = 34;
  localparam int ACC_W = 64;
  // Normalized magnitudes lie below 2^30; their square sum below 2^62.
  localparam int NRM_W = 30;
  localparam int SUM_W = 62;
  localparam int LEN_W = 31;
  // Output component width and saturated magnitude width.
  localparam int OUT_W = 16;
  localparam int QM_W  = 15;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_MAX   = 9'b000001000,
    ST_NORM  = 9'b000010000,
    ST_SQ    = 9'b000100000,
    ST_ROOT  = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // Destination of a finished multiply-accumulate chain.
  typedef enum logic [2:0] {
    TAG_DET = 3'd0,
    TAG_TX  = 3'd1,
    TAG_TY  = 3'd2,
    TAG_TZ  = 3'd3,
    TAG_SUM = 3'd4
  } tag_t;

  // Control that travels with each multiply.
  typedef struct packed {
    logic valid;
    logic clear;
    logic sub;
    logic last;
    tag_t tag;
  } mac_ctl_t;

  // Finished accumulation.
  typedef struct packed {
    logic                    valid;
    tag_t                    tag;
    logic signed [ACC_W-1:0] acc;
  } mac_res_t;

endpackage

`default_nettype wire

FILE: rtl/tut_mac.sv
// Shared signed multiply-accumulate unit: a registered product stage
// followed by an accumulate stage. Depends on tut_pkg.
`default_nettype none

module tut_mac (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire tut_pkg::mac_ctl_t             ctl_i,
  input  wire logic signed [tut_pkg::MUL_W-1:0] a_i,
  input  wire logic signed [tut_pkg::MUL_W-1:0] b_i,
  output tut_pkg::mac_res_t                  res_o
);
  import tut_pkg::*;

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   p_r;
  mac_ctl_t                  ctl1_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic                      done_r;
  tag_t                      tag_r;

  assign prod = a_i * b_i;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
    end
    p_r <= $signed(prod[ACC_W-1:0]);
  end

  // Accumulate stage: start a new chain or add to the running one.
  always_comb begin
    if (ctl1_r.clear) begin
      acc_nxt = ctl1_r.sub ? -p_r : p_r;
    end else begin
      acc_nxt = ctl1_r.sub ? acc_r - p_r : acc_r + p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ctl1_r.valid && ctl1_r.last;
    end
    if (ctl1_r.valid) begin
      acc_r <= acc_nxt;
      tag_r <= ctl1_r.tag;
    end
  end

  assign res_o.valid = done_r;
  assign res_o.tag   = tag_r;
  assign res_o.acc   = acc_r;

endmodule

`default_nettype wire

FILE: rtl/tut_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on tut_pkg for the operand and root widths.
`default_nettype none

module tut_isqrt (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start_i,
  input  wire logic [tut_pkg::SUM_W-1:0]   x_i,
  output logic                             done_o,
  output logic [tut_pkg::LEN_W-1:0]        root_o
);
  import tut_pkg::*;

  localparam int REM_W = LEN_W + 3;
  localparam int CNT_W = $clog2(LEN_W);

  logic [SUM_W-1:0] x_r;
  logic [REM_W-1:0] rem_r;
  logic [LEN_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;
  logic             fits;

  // One digit step: bring down two bits and try the next root bit.
  assign rem2  = {rem_r[REM_W-3:0], x_r[SUM_W-1:SUM_W-2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(LEN_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start_i) begin
      x_r    <= x_i;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      x_r    <= x_r << 2;
      rem_r  <= fits ? rem2 - trial : rem2;
      root_r <= {root_r[LEN_W-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign done_o = done_r;
  assign root_o = root_r;

endmodule

`default_nettype wire

FILE: rtl/tut_div.sv
// Iterative restoring divider for one rounded tangent magnitude,
// one quotient bit per cycle, saturated to 15 bits. Depends on tut_pkg.
`default_nettype none

module tut_div #(
  parameter int FRAC_BITS = tut_pkg::TANGENT_FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start_i,
  input  wire logic [tut_pkg::NRM_W-1:0]  num_i,
  input  wire logic [tut_pkg::LEN_W-1:0]  den_i,
  output logic                            done_o,
  output logic [tut_pkg::QM_W-1:0]        mag_o
);
  import tut_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NW    = NRM_W + QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    n_full;
  logic [LEN_W-1:0] r_r;
  logic [QW-1:0]    nlow_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W:0]   r2;
  logic             fits;

  // Numerator with half the divisor added for round half up.
  assign n_full = NW'({num_i, {FRAC_BITS{1'b0}}}) + NW'(den_i >> 1);

  assign r2   = {r_r, nlow_r[QW-1]};
  assign fits = r2 >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start_i) begin
      r_r    <= LEN_W'(n_full[NW-1:QW]);
      nlow_r <= n_full[QW-1:0];
      q_r    <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      r_r    <= fits ? LEN_W'(r2 - {1'b0, den_i}) : r_r << 1 | LEN_W'(nlow_r[QW-1]);
      nlow_r <= nlow_r << 1;
      q_r    <= {q_r[QW-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Saturate the quotient to the largest Q2 magnitude.
  always_comb begin
    if (q_r > QW'(32767)) begin
      mag_o = '1;
    end else begin
      mag_o = QM_W'(q_r);
    end
  end

  assign done_o = done_r;

endmodule

`default_nettype wire

FILE: rtl/triangle_uv_tangent.sv
// Triangle UV tangent top level: vertex holding, edge capture, sequencer
// and output register. Depends on tut_pkg, tut_mac, tut_isqrt, tut_div.
//
// Usage:
//   Vertices enter on the in_ channel, three transfers per triangle:
//   x, y, z position and u, v texture coordinate. The first two vertices are
//   held and give no result. The third produces one result on the out_
//   channel: a unit tangent in signed Q2.14 and, in out_tuser, a degenerate
//   flag (zero UV determinant or zero tangent; the tangent is then zero).
//   The result of the third vertex comes from eight products on the shared
//   multiplier, up to 29 single-bit normalizing shifts, three squares on
//   the same multiplier, the 31-step square root and the three serial
//   divisions. A degenerate triangle skips the shifts, squares, root and
//   divisions and goes from the products straight to the output register.
//   in_tready is high only while the sequencer is idle. A finished result
//   waits in the output register while the next vertices are taken; a
//   stalled receiver holds the sequencer only once a new result is ready.
//   Reset clears the vertex count and the output valid.
`default_nettype none

module triangle_uv_tangent #(
  parameter int POSITION_BITS     = tut_pkg::POSITION_BITS_DEF,
  parameter int TEXCOORD_BITS     = tut_pkg::TEXCOORD_BITS_DEF,
  parameter int TANGENT_FRAC_BITS = tut_pkg::TANGENT_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // position_x, position_y, position_z, tex_u, tex_v from the lowest bit
  input  wire logic [((3*POSITION_BITS+2*TEXCOORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // tangent_x, tangent_y, tangent_z from the lowest bit
  output logic [3*tut_pkg::OUT_W-1:0]  out_tdata,
  // degenerate
  output logic                         out_tuser
);
  import tut_pkg::*;

  localparam int P   = POSITION_BITS;
  localparam int T   = TEXCOORD_BITS;
  localparam int PW1 = P + 1;
  localparam int TW1 = T + 1;
  localparam int PSH = (P > 32) ? P - 32 : 0;
  localparam int TSH = (T > 24) ? T - 24 : 0;

  // Position edge, brought back to 33 bits truncating toward zero.
  function automatic logic signed [EP_W-1:0] pos_edge(
    input logic signed [P-1:0] b,
    input logic signed [P-1:0] a
  );
    logic signed [PW1-1:0] d;
    logic signed [PW1-1:0] adj;
    d   = PW1'(b) - PW1'(a);
    adj = d + ((d < 0) ? PW1'((64'd1 << PSH) - 64'd1) : PW1'(0));
    return EP_W'(adj >>> PSH);
  endfunction

  // Texture edge, brought back to 25 bits truncating toward zero.
  function automatic logic signed [ET_W-1:0] tex_edge(
    input logic signed [T-1:0] b,
    input logic signed [T-1:0] a
  );
    logic signed [TW1-1:0] d;
    logic signed [TW1-1:0] adj;
    d   = TW1'(b) - TW1'(a);
    adj = d + ((d < 0) ? TW1'((64'd1 << TSH) - 64'd1) : TW1'(0));
    return ET_W'(adj >>> TSH);
  endfunction

  // Input fields.
  logic signed [P-1:0] in_pos [3];
  logic signed [T-1:0] in_u;
  logic signed [T-1:0] in_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = $signed(in_tdata[i*P +: P]);
    end
    in_u = $signed(in_tdata[3*P +: T]);
    in_v = $signed(in_tdata[3*P+T +: T]);
  end

  // Held vertices and captured edges.
  logic signed [P-1:0]    p1_r [3];
  logic signed [P-1:0]    p2_r [3];
  logic signed [T-1:0]    u1_r, v1_r, u2_r, v2_r;
  logic [1:0]             slot_r;
  logic signed [EP_W-1:0] e1_r [3];
  logic signed [EP_W-1:0] e2_r [3];
  logic signed [ET_W-1:0] du1_r, dv1_r, du2_r, dv2_r;

  // Sequencer state.
  state_t              state_r, state_nxt;
  logic [3:0]          op_r;
  logic [1:0]          comp_r;
  logic                div_go_r;
  logic signed [ACC_W-1:0] det_r;
  logic signed [T_W-1:0]   t_r [3];
  logic [T_W-1:0]      mag_r [3];
  logic [T_W-1:0]      m_r;
  logic [2:0]          neg_r;
  logic                degen_r;
  logic [LEN_W-1:0]    len_r;
  logic [QM_W-1:0]     q_r [3];

  logic                in_fire;
  logic                third;
  logic                t_zero;
  logic [T_W-1:0]      max01;

  // Shared unit hookup.
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a;
  logic signed [MUL_W-1:0] mac_b;
  mac_res_t                mac_res;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [LEN_W-1:0]        sqrt_root;
  logic                    div_done;
  logic [QM_W-1:0]         div_mag;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign third     = in_fire && (slot_r == 2'd2);

  // Vertex holding and edge capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
    end else if (in_fire) begin
      slot_r <= (slot_r == 2'd1) ? 2'd2 : (slot_r == 2'd2) ? 2'd0 : 2'd1;
    end
    if (in_fire && slot_r == 2'd1) begin
      p2_r <= in_pos;
      u2_r <= in_u;
      v2_r <= in_v;
    end else if (in_fire && slot_r != 2'd2) begin
      p1_r <= in_pos;
      u1_r <= in_u;
      v1_r <= in_v;
    end
    if (third) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= pos_edge(p2_r[i], p1_r[i]);
        e2_r[i] <= pos_edge(in_pos[i], p1_r[i]);
      end
      du1_r <= tex_edge(u2_r, u1_r);
      dv1_r <= tex_edge(v2_r, v1_r);
      du2_r <= tex_edge(in_u, u1_r);
      dv2_r <= tex_edge(in_v, v1_r);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    if (state_r == ST_MUL && op_r < 4'd8) begin
      mac_ctl.valid = 1'b1;
      mac_ctl.clear = ~op_r[0];
      mac_ctl.sub   = op_r[0];
      mac_ctl.last  = op_r[0];
      mac_a = op_r[0] ? MUL_W'(dv1_r) : MUL_W'(dv2_r);
      case (op_r[3:1])
        3'd0: begin
          mac_ctl.tag = TAG_DET;
          mac_b = op_r[0] ? MUL_W'(du2_r) : MUL_W'(du1_r);
        end
        3'd1: begin
          mac_ctl.tag = TAG_TX;
          mac_b = op_r[0] ? MUL_W'(e2_r[0]) : MUL_W'(e1_r[0]);
        end
        3'd2: begin
          mac_ctl.tag = TAG_TY;
          mac_b = op_r[0] ? MUL_W'(e2_r[1]) : MUL_W'(e1_r[1]);
        end
        3'd3: begin
          mac_ctl.tag = TAG_TZ;
          mac_b = op_r[0] ? MUL_W'(e2_r[2]) : MUL_W'(e1_r[2]);
        end
        default: begin
          mac_ctl.tag = TAG_DET;
        end
      endcase
    end else if (state_r == ST_SQ && op_r < 4'd3) begin
      mac_ctl.valid = 1'b1;
      mac_ctl.clear = (op_r == 4'd0);
      mac_ctl.sub   = 1'b0;
      mac_ctl.last  = (op_r == 4'd2);
      mac_ctl.tag   = TAG_SUM;
      mac_a = $signed(MUL_W'(mag_r[op_r[1:0]][NRM_W-1:0]));
      mac_b = mac_a;
    end
  end

  tut_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .res_o (mac_res)
  );

  assign sqrt_start = (state_r == ST_SQ) && mac_res.valid && (mac_res.tag == TAG_SUM);

  tut_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sqrt_start),
    .x_i     (SUM_W'(mac_res.acc)),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  tut_div #(
    .FRAC_BITS (TANGENT_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_go_r),
    .num_i   (mag_r[comp_r][NRM_W-1:0]),
    .den_i   (len_r),
    .done_o  (div_done),
    .mag_o   (div_mag)
  );

  assign t_zero = (t_r[0] == '0) && (t_r[1] == '0) && (t_r[2] == '0);
  assign max01  = (mag_r[1] > mag_r[0]) ? mag_r[1] : mag_r[0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (third) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mac_res.valid && mac_res.tag == TAG_TZ) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (det_r == '0 || t_zero) ? ST_OUT : ST_MAX;
      end
      ST_MAX: begin
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (m_r[T_W-1:NRM_W] == '0 && m_r[NRM_W-1]) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (sqrt_start) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && comp_r == 2'd2) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers and datapath capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= '0;
      comp_r   <= '0;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= 1'b0;
      if (state_r != state_nxt) begin
        op_r <= '0;
      end else if (mac_ctl.valid) begin
        op_r <= op_r + 1'b1;
      end
      if (state_r == ST_ROOT && sqrt_done) begin
        comp_r   <= 2'd0;
        div_go_r <= 1'b1;
      end else if (state_r == ST_DIV && div_done && comp_r != 2'd2) begin
        comp_r   <= comp_r + 1'b1;
        div_go_r <= 1'b1;
      end
    end
    // Accumulator results.
    if (mac_res.valid) begin
      case (mac_res.tag)
        TAG_DET: det_r  <= mac_res.acc;
        TAG_TX:  t_r[0] <= T_W'(mac_res.acc);
        TAG_TY:  t_r[1] <= T_W'(mac_res.acc);
        TAG_TZ:  t_r[2] <= T_W'(mac_res.acc);
        default: ;
      endcase
    end
    // Signs, magnitudes and the degenerate decision.
    if (state_r == ST_CHECK) begin
      degen_r <= (det_r == '0) || t_zero;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= t_r[i][T_W-1] ^ det_r[ACC_W-1];
        mag_r[i] <= t_r[i][T_W-1] ? T_W'(-t_r[i]) : T_W'(t_r[i]);
      end
    end
    if (state_r == ST_MAX) begin
      m_r <= (mag_r[2] > max01) ? mag_r[2] : max01;
    end
    // One bit of normalizing shift per cycle.
    if (state_r == ST_NORM) begin
      if (m_r[T_W-1:NRM_W] != '0) begin
        m_r <= m_r >> 1;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end else if (!m_r[NRM_W-1]) begin
        m_r <= m_r << 1;
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
      end
    end
    if (state_r == ST_ROOT && sqrt_done) begin
      len_r <= sqrt_root;
    end
    if (state_r == ST_DIV && div_done) begin
      q_r[comp_r] <= div_mag;
    end
  end

  // Output register.
  logic [3*OUT_W-1:0] out_data_r;
  logic               out_user_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   res_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen_r) begin
        res_c[i] = '0;
      end else if (neg_r[i]) begin
        res_c[i] = OUT_W'(0) - OUT_W'(q_r[i]);
      end else begin
        res_c[i] = OUT_W'(q_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {res_c[2], res_c[1], res_c[0]};
      out_user_r <= degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A degenerate result always carries a zero tangent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero tangent");

  // The shared multiplier finishes chains only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (!rst_n)
    mac_res.valid |-> (state_r == ST_MUL || state_r == ST_SQ))
    else $error("multiplier result outside its states");

  // The divider reports only during the division phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider result outside division phase");

  // The vertex count never reaches three.
  assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("vertex count out of range");

endmodule

`default_nettype wire

FILE: tb/sv/tangent_checker.sv
// Checker for the triangle UV tangent block: watches both stream channels,
// predicts each tangent from the accepted vertices and compares results.
// Depends on no package; field widths are those of the default sizes.
`timescale 1ns / 100ps

module tangent_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [143:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [47:0]  out_tdata,
  input  wire         out_tuser,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          degenerate_count
);

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic               degen;
  } tangent_t;

  tangent_t tangent_q[$];

  // Held vertices of the triangle being gathered.
  logic signed [31:0] held_pos[6];
  logic signed [23:0] held_uv[4];
  int unsigned        slot;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Tangent of one triangle from its third vertex and the held two.
  function automatic tangent_t triangle_tangent(input logic signed [31:0] p[3],
                                                input logic signed [23:0] u,
                                                input logic signed [23:0] v);
    tangent_t           r;
    logic signed [63:0] e1[3], e2[3], t[3];
    logic signed [63:0] du1, dv1, du2, dv2, det;
    logic [63:0]        mag[3], m, sum, len, q;
    logic               neg[3];
    r = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 64'(held_pos[3+i]) - 64'(held_pos[i]);
      e2[i] = 64'(p[i]) - 64'(held_pos[i]);
    end
    du1 = 64'(held_uv[2]) - 64'(held_uv[0]);
    dv1 = 64'(held_uv[3]) - 64'(held_uv[1]);
    du2 = 64'(u) - 64'(held_uv[0]);
    dv2 = 64'(v) - 64'(held_uv[1]);
    det = du1 * dv2 - du2 * dv1;
    r.degen = 1'b1;
    if (det == 0) return r;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = dv2 * e1[i] - dv1 * e2[i];
      neg[i] = (t[i] < 0) != (det < 0);
      mag[i] = t[i] < 0 ? -t[i] : t[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return r;
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    r.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 14) + (len >> 1)) / len;
      if (q > 32767) q = 32767;
      if (i == 0) r.tx = neg[i] ? -16'(q) : 16'(q);
      if (i == 1) r.ty = neg[i] ? -16'(q) : 16'(q);
      if (i == 2) r.tz = neg[i] ? -16'(q) : 16'(q);
    end
    return r;
  endfunction

  assign pending_count = tangent_q.size();

  // Track vertex transfers and compare result transfers.
  always @(posedge clk) begin
    logic signed [31:0] p[3];
    tangent_t           want, got, next_t;
    if (!rst_n) begin
      slot <= 0;
      fail_count <= 0;
      result_count <= 0;
      degenerate_count <= 0;
      for (int i = 0; i < 6; i++) held_pos[i] <= '0;
      for (int i = 0; i < 4; i++) held_uv[i] <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < 3; i++) p[i] = in_tdata[32*i +: 32];
        if (slot == 1) begin
          for (int i = 0; i < 3; i++) held_pos[3+i] <= p[i];
          held_uv[2] <= in_tdata[96 +: 24];
          held_uv[3] <= in_tdata[120 +: 24];
          slot <= 2;
        end else if (slot == 2) begin
          next_t = triangle_tangent(p, in_tdata[96 +: 24], in_tdata[120 +: 24]);
          tangent_q = {tangent_q, next_t};
          slot <= 0;
        end else begin
          for (int i = 0; i < 3; i++) held_pos[i] <= p[i];
          held_uv[0] <= in_tdata[96 +: 24];
          held_uv[1] <= in_tdata[120 +: 24];
          slot <= 1;
        end
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser};
        result_count <= result_count + 1;
        if (got.degen) degenerate_count <= degenerate_count + 1;
        if (tangent_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", got);
        end else begin
          want = tangent_q.pop_front();
          if (want !== got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"tangent mismatch: expected x=%0d y=%0d z=%0d degen=%0b,",
                        " got x=%0d y=%0d z=%0d degen=%0b"},
                       want.tx, want.ty, want.tz, want.degen,
                       got.tx, got.ty, got.tz, got.degen);
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top for triangle_uv_tangent: drives vertex transfers with random
// gaps and receiver stalls, and reports the verdict. Depends on tangent_checker.
`timescale 1ns / 100ps

module testbench;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic [143:0] in_tdata = '0;
  logic         out_tready = 1'b0;
  wire          in_tready;
  wire          out_tvalid;
  wire  [47:0]  out_tdata;
  wire          out_tuser;
  int           fail_count, pending_count, result_count, degenerate_count;
  int           cycle_count = 0;
  int           vertex_count = 0;
  bit           calm_phase = 1'b0;
  bit           long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_uv_tangent u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  tangent_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .degenerate_count(degenerate_count)
  );

  // Cycle limit well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one vertex, at times with a random gap first, and wait for its transfer.
  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [23:0] u,
                             input logic [23:0] v);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, u, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    vertex_count++;
  endtask

  function automatic logic [31:0] rand_pos(input int style);
    case (style)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8192)) - 4096) << 12;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  function automatic logic [23:0] rand_uv(input int style);
    case (style)
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 65536));
      2: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      default: return 24'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic random_triangle();
    int ps, us;
    logic [23:0] u0, v0;
    ps = $urandom_range(0, 3);
    us = $urandom_range(0, 3);
    u0 = rand_uv(us);
    v0 = rand_uv(us);
    for (int k = 0; k < 3; k++) begin
      // Occasionally repeat the first UV to force a zero determinant.
      if (k > 0 && $urandom_range(0, 15) == 0)
        send_vertex(rand_pos(ps), rand_pos(ps), rand_pos(ps), u0, v0);
      else
        send_vertex(rand_pos(ps), rand_pos(ps), rand_pos(ps),
                    k == 0 ? u0 : rand_uv(us), k == 0 ? v0 : rand_uv(us));
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ordinary triangle, field extremes, zero determinant, a zero
    // tangent (all positions equal) and a triangle mixing minus one, zero and one.
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h0001_0000, 0, 0, 24'h01_0000, 0);
    send_vertex(0, 32'h0001_0000, 0, 0, 24'h01_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000, 24'h7F_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
    send_vertex(5, 6, 7, 24'h00_1000, 24'h00_2000);
    send_vertex(9, 1, 3, 24'h00_1000, 24'h00_2000);
    send_vertex(2, 8, 4, 24'h00_1000, 24'h00_2000);
    send_vertex(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 0, 0);
    send_vertex(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 24'h01_0000, 0);
    send_vertex(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 0, 24'h01_0000);
    send_vertex(32'hFFFF_FFFF, 0, 0, 24'hFF_FFFF, 0);
    send_vertex(0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 24'hFF_FFFF);
    send_vertex(1, 0, 32'hFFFF_FFFF, 24'h00_0001, 24'h00_0001);

    // Long receiver hold-off while vertices keep coming.
    long_hold = 1'b1;
    for (int i = 0; i < 15; i++) random_triangle();

    for (int i = 0; i < 120; i++) random_triangle();
    calm_phase = 1'b1;
    for (int i = 0; i < 30; i++) random_triangle();
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);

    $display("Sent %0d vertices; checked %0d tangents, %0d degenerate.",
             vertex_count, result_count, degenerate_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
